### rtl/core/jpd_pkg.sv
// Package for the joint PD servo: item control type, field widths and codes.
// Used by every module of the block; depends on nothing else.
package jpd_pkg;

	localparam int Q_W     = 32;
	localparam int GAIN_W  = 31;
	localparam int ROW_W   = 3;
	localparam int COUNT_W = 4;
	localparam int CFG_W   = 63;
	localparam int PROD_W  = 64;
	localparam int TERM_W  = 48;
	localparam int SUM_W   = 64;
	localparam int ACC_W   = 64;
	localparam int FRAC_W  = 16;
	localparam int ROW_LIM = 8;

	localparam logic FUNC_JOINT = 1'b0;
	localparam logic FUNC_MASS  = 1'b1;

	localparam logic KIND_TASK  = 1'b0;
	localparam logic KIND_JOINT = 1'b1;

	localparam logic CFG_JOINT_COUNT = 1'b0;
	localparam logic CFG_RES_SQ      = 1'b1;

	localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd8;

	typedef struct packed {
		logic             valid;
		logic             func;
		logic [ROW_W-1:0] row;
		logic [ROW_W-1:0] col;
		logic             last;
	} jpd_ctl_t;

endpackage

### rtl/core/jpd_cfg.sv
// Configuration registers of the joint PD servo and the effective joint count.
// Depends on jpd_pkg.
module jpd_cfg #(
	parameter int MAX_JOINTS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [jpd_pkg::CFG_W-1:0]     cfg_data,
	output logic [jpd_pkg::COUNT_W-1:0]   joints_in_use,
	output logic [jpd_pkg::CFG_W-1:0]     resolution_sq
);
	import jpd_pkg::*;

	localparam int LimInt = (MAX_JOINTS < ROW_LIM) ? MAX_JOINTS : ROW_LIM;
	localparam logic [COUNT_W-1:0] Limit = COUNT_W'(LimInt);

	logic [COUNT_W-1:0] joint_count_q;
	logic [CFG_W-1:0]   res_sq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			joint_count_q <= COUNT_RESET;
			res_sq_q      <= '0;
		end else if (cfg_we) begin
			if (cfg_index == CFG_JOINT_COUNT) begin
				joint_count_q <= cfg_data[COUNT_W-1:0];
			end else begin
				res_sq_q <= cfg_data;
			end
		end
	end

	always_comb begin
		if (joint_count_q == '0) begin
			joints_in_use = COUNT_W'(1);
		end else if (joint_count_q > Limit) begin
			joints_in_use = Limit;
		end else begin
			joints_in_use = joint_count_q;
		end
	end

	assign resolution_sq = res_sq_q;

endmodule

### rtl/core/jpd_joint.sv
// Joint path: PD products, sum and clamp, the stored task forces and the error sum.
// Depends on jpd_pkg.
module jpd_joint #(
	parameter int MAX_JOINTS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  jpd_pkg::jpd_ctl_t                   ctl_s1,
	input  jpd_pkg::jpd_ctl_t                   ctl_s2,
	input  jpd_pkg::jpd_ctl_t                   ctl_s3,
	input  logic signed [jpd_pkg::Q_W-1:0]      position_s1,
	input  logic signed [jpd_pkg::Q_W-1:0]      velocity_s1,
	input  logic signed [jpd_pkg::Q_W-1:0]      goal_s1,
	input  logic [jpd_pkg::GAIN_W-1:0]          pos_gain_s1,
	input  logic [jpd_pkg::GAIN_W-1:0]          vel_gain_s1,
	input  logic signed [jpd_pkg::Q_W-1:0]      force_lo_s1,
	input  logic signed [jpd_pkg::Q_W-1:0]      force_hi_s1,
	input  logic [jpd_pkg::CFG_W-1:0]           resolution_sq,
	output logic signed [jpd_pkg::Q_W-1:0]      store_rd,
	output logic signed [jpd_pkg::Q_W-1:0]      task_force_s3,
	output logic                                at_goal
);
	import jpd_pkg::*;

	localparam int StoreDepth = (MAX_JOINTS < ROW_LIM) ? MAX_JOINTS : ROW_LIM;
	localparam int StoreAw    = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;

	logic signed [Q_W:0]      err;
	logic signed [Q_W:0]      neg_vel;
	logic signed [PROD_W:0]   kp_prod;
	logic signed [PROD_W:0]   kv_prod;
	logic signed [PROD_W+1:0] sq_prod;

	logic signed [PROD_W-1:0] kp_prod_s2;
	logic signed [PROD_W-1:0] kv_prod_s2;
	logic [SUM_W-1:0]         sq_s2;
	logic signed [Q_W-1:0]    lo_s2;
	logic signed [Q_W-1:0]    hi_s2;

	logic signed [TERM_W:0]   f_sum;
	logic signed [TERM_W:0]   f_hi;
	logic signed [TERM_W:0]   f_lo;
	logic signed [TERM_W:0]   f_top;
	logic signed [TERM_W:0]   f_bot;
	logic signed [Q_W-1:0]    f_clamp;

	logic [SUM_W:0]           sum_ext;
	logic [SUM_W-1:0]         sum_next;

	logic signed [Q_W-1:0]    store_q [StoreDepth];
	logic [SUM_W-1:0]         err_sum_q;
	logic signed [Q_W-1:0]    f_s3;
	logic                     joint_b;

	assign err     = $signed({goal_s1[Q_W-1], goal_s1}) - $signed({position_s1[Q_W-1], position_s1});
	assign neg_vel = -$signed({velocity_s1[Q_W-1], velocity_s1});
	assign kp_prod = $signed({1'b0, pos_gain_s1}) * err;
	assign kv_prod = $signed({1'b0, vel_gain_s1}) * neg_vel;
	assign sq_prod = err * err;

	always_ff @(posedge clk) begin
		if (ctl_s1.valid && ctl_s1.func == FUNC_JOINT) begin
			kp_prod_s2 <= kp_prod[PROD_W-1:0];
			kv_prod_s2 <= kv_prod[PROD_W-1:0];
			sq_s2      <= sq_prod[SUM_W-1:0];
			lo_s2      <= force_lo_s1;
			hi_s2      <= force_hi_s1;
		end
	end

	// Dropping the low fraction bits of an exact product floors it to Q16.16.
	assign f_sum = $signed({kp_prod_s2[PROD_W-1], kp_prod_s2[PROD_W-1:FRAC_W]})
		+ $signed({kv_prod_s2[PROD_W-1], kv_prod_s2[PROD_W-1:FRAC_W]});
	assign f_hi  = (TERM_W+1)'(hi_s2);
	assign f_lo  = (TERM_W+1)'(lo_s2);
	assign f_top = (f_sum > f_hi) ? f_hi : f_sum;
	assign f_bot = (f_top < f_lo) ? f_lo : f_top;
	assign f_clamp = f_bot[Q_W-1:0];

	assign sum_ext = {1'b0, err_sum_q} + {1'b0, sq_s2};
	always_comb begin
		if (ctl_s2.row == '0) begin
			sum_next = sq_s2;
		end else if (sum_ext[SUM_W]) begin
			sum_next = '1;
		end else begin
			sum_next = sum_ext[SUM_W-1:0];
		end
	end

	assign joint_b = ctl_s2.valid && ctl_s2.func == FUNC_JOINT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < StoreDepth; i++) begin
				store_q[i] <= '0;
			end
			err_sum_q <= '0;
		end else if (joint_b) begin
			store_q[ctl_s2.row[StoreAw-1:0]] <= f_clamp;
			err_sum_q <= sum_next;
		end
	end

	always_ff @(posedge clk) begin
		if (joint_b) begin
			f_s3 <= f_clamp;
		end
	end

	assign store_rd      = store_q[ctl_s2.col[StoreAw-1:0]];
	assign task_force_s3 = f_s3;
	assign at_goal       = ctl_s3.func == FUNC_JOINT && err_sum_q <= {1'b0, resolution_sq};

	a_clamp_in_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(joint_b && lo_s2 <= hi_s2) |-> (f_clamp >= lo_s2 && f_clamp <= hi_s2))
		else $error("Clamped force left its bounds.");

	a_err_sum_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(joint_b && ctl_s2.row != '0) |=> (err_sum_q >= $past(err_sum_q)))
		else $error("Error sum shrank without a restart.");

endmodule

### rtl/core/jpd_mass.sv
// Mass-matrix path: element times stored task force, row accumulation and gravity.
// Depends on jpd_pkg.
module jpd_mass (
	input  logic                            clk,
	input  logic                            arst_n,
	input  jpd_pkg::jpd_ctl_t               ctl_s2,
	input  jpd_pkg::jpd_ctl_t               ctl_s3,
	input  logic signed [jpd_pkg::Q_W-1:0]  mass_s2,
	input  logic signed [jpd_pkg::Q_W-1:0]  store_rd,
	input  logic signed [jpd_pkg::Q_W-1:0]  gravity_s3,
	output logic signed [jpd_pkg::Q_W-1:0]  joint_force
);
	import jpd_pkg::*;

	logic signed [PROD_W-1:0] prod_s3;
	logic signed [ACC_W-1:0]  term;
	logic signed [ACC_W-1:0]  acc_next;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W:0]    diff;
	logic                     mass_c;

	always_ff @(posedge clk) begin
		if (ctl_s2.valid && ctl_s2.func == FUNC_MASS) begin
			prod_s3 <= mass_s2 * store_rd;
		end
	end

	assign term     = ACC_W'($signed(prod_s3[PROD_W-1:FRAC_W]));
	assign acc_next = (ctl_s3.col == '0) ? term : acc_q + term;
	assign diff     = (ACC_W+1)'(acc_next) - (ACC_W+1)'(gravity_s3);
	assign mass_c   = ctl_s3.valid && ctl_s3.func == FUNC_MASS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (mass_c) begin
			acc_q <= acc_next;
		end
	end

	always_comb begin
		if (diff > (ACC_W+1)'(32'sh7fffffff)) begin
			joint_force = 32'sh7fffffff;
		end else if (diff < (ACC_W+1)'(-33'sh080000000)) begin
			joint_force = 32'sh80000000;
		end else begin
			joint_force = diff[Q_W-1:0];
		end
	end

endmodule

### rtl/core/joint_pd_servo_mass_scaled.sv
// Top level of the joint PD servo with mass-matrix scaling and gravity compensation.
// Instantiates jpd_cfg, jpd_joint and jpd_mass; depends on jpd_pkg.
//
// An item is taken at a rising edge with start high; busy is always low, so an item
// may be given in every cycle. A joint item (func 0) yields a task force result. A
// mass item (func 1) adds one matrix element times a stored task force to the row sum
// and yields a joint force result at the last column in use. Items whose row, or
// column for a mass item, is not below the joint count give no result.
// Each result is shown for one cycle with done high, in item order. The pipeline is
// input register, product stage, clamp and store stage, result register; one item a
// cycle is sustained. The receiver cannot stall; results must be taken when done
// is high. Configuration writes through cfg_we, cfg_index and cfg_data take effect
// at once; the user must make them only while no item is in flight, as the block
// does not enforce this. Reset clears the stored task forces, the sums and the
// pipeline, and sets the joint count to eight and the tolerance to zero.
module joint_pd_servo_mass_scaled #(
	parameter int MAX_JOINTS = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic                            cfg_we,
	input  logic                            cfg_index,
	input  logic [jpd_pkg::CFG_W-1:0]       cfg_data,
	input  logic                            func,
	input  logic [jpd_pkg::ROW_W-1:0]       row,
	input  logic [jpd_pkg::ROW_W-1:0]       col,
	input  logic signed [jpd_pkg::Q_W-1:0]  position,
	input  logic signed [jpd_pkg::Q_W-1:0]  velocity,
	input  logic signed [jpd_pkg::Q_W-1:0]  goal,
	input  logic [jpd_pkg::GAIN_W-1:0]      pos_gain,
	input  logic [jpd_pkg::GAIN_W-1:0]      vel_gain,
	input  logic signed [jpd_pkg::Q_W-1:0]  force_lo,
	input  logic signed [jpd_pkg::Q_W-1:0]  force_hi,
	input  logic signed [jpd_pkg::Q_W-1:0]  mass_value,
	input  logic signed [jpd_pkg::Q_W-1:0]  gravity_value,
	output logic                            done,
	output logic                            kind,
	output logic [jpd_pkg::ROW_W-1:0]       out_row,
	output logic signed [jpd_pkg::Q_W-1:0]  task_force,
	output logic signed [jpd_pkg::Q_W-1:0]  joint_force,
	output logic                            at_goal
);
	import jpd_pkg::*;

	logic [COUNT_W-1:0]    joints_in_use;
	logic [CFG_W-1:0]      resolution_sq;
	logic                  in_use;
	jpd_ctl_t              ctl_in;
	jpd_ctl_t              ctl_s1;
	jpd_ctl_t              ctl_s2;
	jpd_ctl_t              ctl_s3;

	logic signed [Q_W-1:0] position_s1;
	logic signed [Q_W-1:0] velocity_s1;
	logic signed [Q_W-1:0] goal_s1;
	logic [GAIN_W-1:0]     pos_gain_s1;
	logic [GAIN_W-1:0]     vel_gain_s1;
	logic signed [Q_W-1:0] force_lo_s1;
	logic signed [Q_W-1:0] force_hi_s1;
	logic signed [Q_W-1:0] mass_s1;
	logic signed [Q_W-1:0] gravity_s1;
	logic signed [Q_W-1:0] mass_s2;
	logic signed [Q_W-1:0] gravity_s2;
	logic signed [Q_W-1:0] gravity_s3;

	logic signed [Q_W-1:0] store_rd;
	logic signed [Q_W-1:0] task_force_s3;
	logic                  at_goal_c;
	logic signed [Q_W-1:0] joint_force_c;

	logic                  done_q;
	logic                  kind_q;
	logic [ROW_W-1:0]      out_row_q;
	logic signed [Q_W-1:0] task_force_q;
	logic signed [Q_W-1:0] joint_force_q;
	logic                  at_goal_q;

	jpd_cfg #(
		.MAX_JOINTS(MAX_JOINTS)
	) u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.joints_in_use(joints_in_use),
		.resolution_sq(resolution_sq)
	);

	assign busy = 1'b0;

	assign in_use = ({1'b0, row} < joints_in_use)
		&& (func == FUNC_JOINT || {1'b0, col} < joints_in_use);

	always_comb begin
		ctl_in.valid = start && !busy && in_use;
		ctl_in.func  = func;
		ctl_in.row   = row;
		ctl_in.col   = col;
		ctl_in.last  = ({1'b0, col} == joints_in_use - COUNT_W'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_in.valid) begin
			position_s1 <= position;
			velocity_s1 <= velocity;
			goal_s1     <= goal;
			pos_gain_s1 <= pos_gain;
			vel_gain_s1 <= vel_gain;
			force_lo_s1 <= force_lo;
			force_hi_s1 <= force_hi;
			mass_s1     <= mass_value;
			gravity_s1  <= gravity_value;
		end
		if (ctl_s1.valid) begin
			mass_s2    <= mass_s1;
			gravity_s2 <= gravity_s1;
		end
		if (ctl_s2.valid) begin
			gravity_s3 <= gravity_s2;
		end
	end

	jpd_joint #(
		.MAX_JOINTS(MAX_JOINTS)
	) u_joint (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl_s1       (ctl_s1),
		.ctl_s2       (ctl_s2),
		.ctl_s3       (ctl_s3),
		.position_s1  (position_s1),
		.velocity_s1  (velocity_s1),
		.goal_s1      (goal_s1),
		.pos_gain_s1  (pos_gain_s1),
		.vel_gain_s1  (vel_gain_s1),
		.force_lo_s1  (force_lo_s1),
		.force_hi_s1  (force_hi_s1),
		.resolution_sq(resolution_sq),
		.store_rd     (store_rd),
		.task_force_s3(task_force_s3),
		.at_goal      (at_goal_c)
	);

	jpd_mass u_mass (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl_s2     (ctl_s2),
		.ctl_s3     (ctl_s3),
		.mass_s2    (mass_s2),
		.store_rd   (store_rd),
		.gravity_s3 (gravity_s3),
		.joint_force(joint_force_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl_s3.valid && (ctl_s3.func == FUNC_JOINT || ctl_s3.last);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_s3.valid) begin
			out_row_q <= ctl_s3.row;
			if (ctl_s3.func == FUNC_JOINT) begin
				kind_q        <= KIND_TASK;
				task_force_q  <= task_force_s3;
				joint_force_q <= '0;
				at_goal_q     <= at_goal_c;
			end else begin
				kind_q        <= KIND_JOINT;
				task_force_q  <= '0;
				joint_force_q <= joint_force_c;
				at_goal_q     <= 1'b0;
			end
		end
	end

	assign done        = done_q;
	assign kind        = kind_q;
	assign out_row     = out_row_q;
	assign task_force  = task_force_q;
	assign joint_force = joint_force_q;
	assign at_goal     = at_goal_q;

	a_result_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 4))
		else $error("A result appeared without an item taken four cycles before.");

endmodule

### sim/joint_pd_servo_mass_scaled_tb.sv
// Testbench for joint_pd_servo_mass_scaled: directed and random joint and mass-matrix items,
// sent with random gaps, each result checked against a predictor of the servo kept here.
// Depends on jpd_pkg and the RTL of the block.
module joint_pd_servo_mass_scaled_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import jpd_pkg::*;

	localparam int ITEM_TARGET = 1750;
	localparam int GAP_MAX = 6;
	localparam int SETTLE_CYCLES = 8;
	localparam int JOINT_LIMIT = 8;
	localparam logic [Q_W-1:0] Q_MIN = 32'h8000_0000;
	localparam logic [Q_W-1:0] Q_MAX = 32'h7fff_ffff;
	localparam logic [GAIN_W-1:0] GAIN_MAX = '1;
	localparam logic [CFG_W-1:0] TOL_MAX = '1;
	localparam logic [SUM_W-1:0] SUM_MAX = '1;

	typedef enum logic [1:0] {STEP_ITEM, STEP_CONFIG, STEP_DRAIN} step_kind_e;

	typedef struct packed {
		step_kind_e         op;
		logic [2:0]         gap;
		logic               func;
		logic [ROW_W-1:0]   row;
		logic [ROW_W-1:0]   col;
		logic [Q_W-1:0]     position;
		logic [Q_W-1:0]     velocity;
		logic [Q_W-1:0]     goal;
		logic [GAIN_W-1:0]  pos_gain;
		logic [GAIN_W-1:0]  vel_gain;
		logic [Q_W-1:0]     force_lo;
		logic [Q_W-1:0]     force_hi;
		logic [Q_W-1:0]     mass_value;
		logic [Q_W-1:0]     gravity_value;
		logic               cfg_sel;
		logic [CFG_W-1:0]   cfg_value;
	} plan_step_t;

	typedef struct packed {
		logic               kind;
		logic [ROW_W-1:0]   row;
		logic [Q_W-1:0]     task_force;
		logic [Q_W-1:0]     joint_force;
		logic               at_goal;
	} force_result_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   start = 1'b0;
	logic                   busy;
	logic                   cfg_we = 1'b0;
	logic                   cfg_index = CFG_JOINT_COUNT;
	logic [CFG_W-1:0]       cfg_data = '0;
	logic                   func = FUNC_JOINT;
	logic [ROW_W-1:0]       row = '0;
	logic [ROW_W-1:0]       col = '0;
	logic signed [Q_W-1:0]  position = '0;
	logic signed [Q_W-1:0]  velocity = '0;
	logic signed [Q_W-1:0]  goal = '0;
	logic [GAIN_W-1:0]      pos_gain = '0;
	logic [GAIN_W-1:0]      vel_gain = '0;
	logic signed [Q_W-1:0]  force_lo = '0;
	logic signed [Q_W-1:0]  force_hi = '0;
	logic signed [Q_W-1:0]  mass_value = '0;
	logic signed [Q_W-1:0]  gravity_value = '0;
	logic                   done;
	logic                   kind;
	logic [ROW_W-1:0]       out_row;
	logic signed [Q_W-1:0]  task_force;
	logic signed [Q_W-1:0]  joint_force;
	logic                   at_goal;

	plan_step_t             plan[$];
	force_result_t          pending_forces[$];

	logic signed [Q_W-1:0]  task_store [JOINT_LIMIT] = '{default: '0};
	longint                 row_sum = 0;
	logic [SUM_W-1:0]       err_sq_sum = '0;
	logic [COUNT_W-1:0]     count_q = COUNT_RESET;
	logic [CFG_W-1:0]       tol_sq = '0;

	int unsigned            plan_joints = JOINT_LIMIT;
	int                     useful_items = 0;
	int                     failures = 0;
	int                     idle_left = 0;
	int                     quiet = 0;
	logic                   item_taken = 1'b0;
	logic                   steady = 1'b0;

	joint_pd_servo_mass_scaled #(
		.MAX_JOINTS(JOINT_LIMIT)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.func(func),
		.row(row),
		.col(col),
		.position(position),
		.velocity(velocity),
		.goal(goal),
		.pos_gain(pos_gain),
		.vel_gain(vel_gain),
		.force_lo(force_lo),
		.force_hi(force_hi),
		.mass_value(mass_value),
		.gravity_value(gravity_value),
		.done(done),
		.kind(kind),
		.out_row(out_row),
		.task_force(task_force),
		.joint_force(joint_force),
		.at_goal(at_goal)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned joints_in_use(logic [COUNT_W-1:0] cnt);
		if (cnt == '0)
			return 1;
		if (cnt > JOINT_LIMIT)
			return JOINT_LIMIT;
		return int'(cnt);
	endfunction

	// Applies one accepted item to the servo state and queues the result it causes.
	task automatic predict_forces();
		int unsigned n;
		longint err, f, term, diff;
		longint unsigned mag, sq;
		force_result_t r;
		n = joints_in_use(count_q);
		r = '0;
		r.row = row;
		if (row >= n)
			return;
		if (func == FUNC_JOINT) begin
			err = longint'(goal) - longint'(position);
			f = ((longint'(pos_gain) * err) >>> FRAC_W)
				+ ((-(longint'(vel_gain) * longint'(velocity))) >>> FRAC_W);
			if (f > longint'(force_hi))
				f = longint'(force_hi);
			if (f < longint'(force_lo))
				f = longint'(force_lo);
			task_store[row] = f[Q_W-1:0];
			mag = (err < 0) ? -err : err;
			sq = mag * mag;
			if (row == '0)
				err_sq_sum = sq;
			else if (err_sq_sum > SUM_MAX - sq)
				err_sq_sum = SUM_MAX;
			else
				err_sq_sum = err_sq_sum + sq;
			r.kind = KIND_TASK;
			r.task_force = f[Q_W-1:0];
			r.at_goal = (err_sq_sum <= {1'b0, tol_sq});
		end else begin
			if (col >= n)
				return;
			term = (longint'(mass_value) * longint'(task_store[col])) >>> FRAC_W;
			if (col == '0)
				row_sum = term;
			else
				row_sum = row_sum + term;
			if (col != n - 1)
				return;
			diff = row_sum - longint'(gravity_value);
			if (diff > longint'(Q_MAX))
				diff = longint'(Q_MAX);
			if (diff < -longint'(Q_MAX) - 1)
				diff = -longint'(Q_MAX) - 1;
			r.kind = KIND_JOINT;
			r.joint_force = diff[Q_W-1:0];
		end
		pending_forces.push_back(r);
	endtask

	task automatic check_field(string name, logic [Q_W-1:0] want, logic [Q_W-1:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0h, actual %0h", name, want, got);
			failures++;
		end
	endtask

	always @(posedge clk) begin
		force_result_t want;
		if (arst_n) begin
			if (done) begin
				if (pending_forces.size() == 0) begin
					$error("unexpected result for row %0d", out_row);
					failures++;
				end else begin
					want = pending_forces.pop_front();
					check_field("kind", Q_W'(want.kind), Q_W'(kind));
					check_field("out_row", Q_W'(want.row), Q_W'(out_row));
					check_field("task_force", want.task_force, task_force);
					check_field("joint_force", want.joint_force, joint_force);
					check_field("at_goal", Q_W'(want.at_goal), Q_W'(at_goal));
				end
			end
			if (cfg_we) begin
				if (cfg_index == CFG_JOINT_COUNT)
					count_q = cfg_data[COUNT_W-1:0];
				else
					tol_sq = cfg_data;
			end
			if (start && !busy) begin
				predict_forces();
				item_taken = 1'b1;
				quiet = 0;
			end else begin
				item_taken = 1'b0;
				if (quiet < 1000)
					quiet++;
			end
		end
	end

	always @(negedge clk) begin
		logic drive;
		logic write;
		plan_step_t s;
		drive = 1'b0;
		write = 1'b0;
		if (arst_n) begin
			if (start && !item_taken) begin
				drive = 1'b1;
			end else if (idle_left > 0) begin
				idle_left--;
			end else if (plan.size() > 0) begin
				s = plan[0];
				case (s.op)
				STEP_ITEM: begin
					func <= s.func;
					row <= s.row;
					col <= s.col;
					position <= s.position;
					velocity <= s.velocity;
					goal <= s.goal;
					pos_gain <= s.pos_gain;
					vel_gain <= s.vel_gain;
					force_lo <= s.force_lo;
					force_hi <= s.force_hi;
					mass_value <= s.mass_value;
					gravity_value <= s.gravity_value;
					drive = 1'b1;
					idle_left = int'(s.gap);
					void'(plan.pop_front());
				end
				STEP_CONFIG: begin
					cfg_index <= s.cfg_sel;
					cfg_data <= s.cfg_value;
					write = 1'b1;
					void'(plan.pop_front());
				end
				default: begin
					if (pending_forces.size() == 0 && quiet >= SETTLE_CYCLES)
						void'(plan.pop_front());
				end
				endcase
			end
		end
		start <= drive;
		cfg_we <= write;
	end

	function automatic logic [Q_W-1:0] small_q();
		return Q_W'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
	endfunction

	function automatic logic [Q_W-1:0] pick_q();
		case ($urandom_range(0, 9))
		0: return Q_MIN;
		1: return Q_MAX;
		2: return '0;
		3: return '1;
		4, 5: return small_q();
		default: return Q_W'($urandom());
		endcase
	endfunction

	function automatic logic [GAIN_W-1:0] pick_gain();
		case ($urandom_range(0, 5))
		0: return '0;
		1: return GAIN_MAX;
		2, 3: return GAIN_W'($urandom_range(0, 32'h0004_0000));
		default: return GAIN_W'($urandom());
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] pick_tol();
		logic [63:0] rnd;
		rnd = {$urandom(), $urandom()};
		case ($urandom_range(0, 3))
		0: return '0;
		1: return TOL_MAX;
		2: return {27'd0, rnd[35:0]};
		default: return rnd[CFG_W-1:0];
		endcase
	endfunction

	function automatic plan_step_t blank_item();
		plan_step_t s;
		logic [31:0] rnd;
		rnd = $urandom();
		s.op = STEP_ITEM;
		s.gap = steady ? 3'd0 : 3'($urandom_range(0, GAP_MAX));
		s.func = rnd[0];
		s.row = rnd[3:1];
		s.col = rnd[6:4];
		s.position = pick_q();
		s.velocity = pick_q();
		s.goal = pick_q();
		s.pos_gain = pick_gain();
		s.vel_gain = pick_gain();
		s.force_lo = pick_q();
		s.force_hi = pick_q();
		s.mass_value = pick_q();
		s.gravity_value = pick_q();
		s.cfg_sel = CFG_JOINT_COUNT;
		s.cfg_value = '0;
		return s;
	endfunction

	task automatic push_item(plan_step_t s);
		if (s.row < plan_joints && (s.func == FUNC_JOINT || s.col < plan_joints))
			useful_items++;
		plan.push_back(s);
	endtask

	task automatic push_joint(logic [ROW_W-1:0] r, logic [Q_W-1:0] pos, logic [Q_W-1:0] vel,
			logic [Q_W-1:0] gl, logic [GAIN_W-1:0] kp, logic [GAIN_W-1:0] kv,
			logic [Q_W-1:0] lo, logic [Q_W-1:0] hi);
		plan_step_t s;
		s = blank_item();
		s.func = FUNC_JOINT;
		s.row = r;
		s.position = pos;
		s.velocity = vel;
		s.goal = gl;
		s.pos_gain = kp;
		s.vel_gain = kv;
		s.force_lo = lo;
		s.force_hi = hi;
		push_item(s);
	endtask

	task automatic push_mass(logic [ROW_W-1:0] r, logic [ROW_W-1:0] c, logic [Q_W-1:0] m,
			logic [Q_W-1:0] g);
		plan_step_t s;
		s = blank_item();
		s.func = FUNC_MASS;
		s.row = r;
		s.col = c;
		s.mass_value = m;
		s.gravity_value = g;
		push_item(s);
	endtask

	task automatic push_drain();
		plan_step_t s;
		s = '0;
		s.op = STEP_DRAIN;
		plan.push_back(s);
	endtask

	task automatic push_config(logic sel, logic [CFG_W-1:0] value);
		plan_step_t s;
		push_drain();
		s = '0;
		s.op = STEP_CONFIG;
		s.cfg_sel = sel;
		s.cfg_value = value;
		plan.push_back(s);
		if (sel == CFG_JOINT_COUNT)
			plan_joints = joints_in_use(value[COUNT_W-1:0]);
	endtask

	task automatic maybe_noise();
		if ($urandom_range(0, 11) == 0)
			push_item(blank_item());
	endtask

	// One servo period: every joint in use, then every matrix row with column zero first,
	// the last column last and the others shuffled; now and then a column goes missing.
	task automatic push_servo_cycle();
		int cols[$];
		int n, j, k, tmp;
		logic [Q_W-1:0] pos, lo, hi, gl;
		n = int'(plan_joints);
		for (j = 0; j < n; j++) begin
			maybe_noise();
			pos = pick_q();
			case ($urandom_range(0, 3))
			0: begin
				lo = Q_MIN;
				hi = Q_MAX;
			end
			1: begin
				lo = -Q_W'($urandom_range(0, 32'h00ff_ffff));
				hi = Q_W'($urandom_range(0, 32'h00ff_ffff));
			end
			default: begin
				lo = pick_q();
				hi = pick_q();
			end
			endcase
			gl = ($urandom_range(0, 2) == 0) ? pick_q() : pos + small_q();
			push_joint(ROW_W'(j), pos, pick_q(), gl, pick_gain(), pick_gain(), lo, hi);
		end
		for (j = 0; j < n; j++) begin
			cols = {};
			for (k = 1; k + 1 < n; k++)
				cols.push_back(k);
			for (k = cols.size() - 1; k > 0; k--) begin
				tmp = $urandom_range(0, k);
				{cols[k], cols[tmp]} = {cols[tmp], cols[k]};
			end
			cols.push_front(0);
			if (n > 1)
				cols.push_back(n - 1);
			if ($urandom_range(0, 9) == 0)
				cols.delete($urandom_range(0, cols.size() - 1));
			foreach (cols[c]) begin
				maybe_noise();
				push_mass(ROW_W'(j), ROW_W'(cols[c]), pick_q(), pick_q());
			end
		end
	endtask

	initial begin
		logic [63:0] rnd;
		logic [COUNT_W-1:0] cnt;
		int c;

		// Full-scale errors drive the squared error sum into saturation.
		push_joint(3'd0, Q_MIN, Q_MIN, Q_MAX, GAIN_MAX, GAIN_MAX, Q_MIN, Q_MAX);
		push_joint(3'd1, Q_MAX, Q_MAX, Q_MIN, GAIN_MAX, GAIN_MAX, Q_MIN, Q_MAX);
		// Crossed bounds give the lower bound.
		push_joint(3'd2, 32'h0001_0000, '0, 32'h0003_0000, 31'h0001_0000, '0,
			32'h0000_8000, 32'hffff_8000);
		// Tiny negative products round toward minus infinity.
		push_joint(3'd7, 32'd1, 32'd1, '0, 31'd1, 31'd1, Q_MIN, Q_MAX);
		// A zero error on joint zero restarts the sum, so the joint is at its goal.
		push_joint(3'd0, 32'h1234_5678, '0, 32'h1234_5678, GAIN_MAX, GAIN_MAX, Q_MIN, Q_MAX);
		for (c = 0; c < JOINT_LIMIT; c++)
			push_mass(3'd5, ROW_W'(c), c[0] ? Q_MIN : Q_MAX, Q_MIN);
		// Columns out of order; column zero restarts the row sum.
		push_mass(3'd6, 3'd3, Q_MAX, '0);
		push_mass(3'd6, 3'd0, 32'h0001_0000, '0);
		push_mass(3'd3, 3'd7, 32'hffff_0000, Q_MAX);
		// A joint count of zero acts as one: rows and columns past it are ignored.
		push_config(CFG_JOINT_COUNT, '0);
		push_joint(3'd1, small_q(), small_q(), small_q(), GAIN_MAX, GAIN_MAX, Q_MIN, Q_MAX);
		push_mass(3'd0, 3'd1, Q_MAX, Q_MAX);
		push_joint(3'd0, Q_MIN, '0, '0, GAIN_MAX, '0, Q_MIN, Q_MAX);
		push_mass(3'd0, 3'd0, Q_MAX, Q_MIN);
		// Counts above eight act as eight.
		push_config(CFG_JOINT_COUNT, {{(CFG_W - COUNT_W){1'b1}}, 4'hf});
		push_config(CFG_RES_SQ, TOL_MAX);
		push_joint(3'd7, pick_q(), pick_q(), pick_q(), pick_gain(), pick_gain(), Q_MIN, Q_MAX);
		push_joint(3'd0, small_q(), small_q(), small_q(), pick_gain(), pick_gain(), Q_MIN, Q_MAX);

		while (useful_items < ITEM_TARGET) begin
			rnd = {$urandom(), $urandom()};
			case ($urandom_range(0, 5))
			0: cnt = 4'd8;
			1: cnt = 4'd1;
			2: cnt = ($urandom_range(0, 1) == 0) ? 4'd0 : COUNT_W'($urandom_range(9, 15));
			default: cnt = COUNT_W'($urandom_range(1, 8));
			endcase
			push_config(CFG_JOINT_COUNT, {rnd[CFG_W-1:COUNT_W], cnt});
			push_config(CFG_RES_SQ, pick_tol());
			steady = ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(1, 3))
				push_servo_cycle();
			if ($urandom_range(0, 3) == 0)
				push_drain();
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		while (plan.size() != 0 || start || pending_forces.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule

### joint_pd_servo_mass_scaled.f
rtl/core/jpd_pkg.sv
rtl/core/jpd_cfg.sv
rtl/core/jpd_joint.sv
rtl/core/jpd_mass.sv
rtl/core/joint_pd_servo_mass_scaled.sv
sim/joint_pd_servo_mass_scaled_tb.sv
